@@ rtl/lcbb_pkg.sv @@
// Package for the byte-budget LRU tag store.
// Holds sizes, the key and accumulator command types, and shared constants.
// No dependencies.
package lcbb_pkg;

  localparam int ENTRIES    = 16;
  localparam int SIZE_WIDTH = 40;
  localparam int SLOT_W     = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int EVN_W      = $clog2(ENTRIES + 2);
  localparam int BUDGET_W   = 40;
  localparam int TOT_W      = ((SIZE_WIDTH > BUDGET_W) ? SIZE_WIDTH : BUDGET_W) + 1;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 40'd16106127360;

  // Operation codes of the mode field.
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [SIZE_WIDTH-1:0] size_t;
  typedef logic [TOT_W-1:0]      total_t;

  typedef struct packed {
    logic [63:0] points_hash;
    logic [31:0] scale_code;
    logic [15:0] rotation_count;
    logic [15:0] rotation_index;
    logic [15:0] gutter;
  } key_t;

  // Command to the byte accumulator.
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } acc_cmd_t;

endpackage

@@ rtl/lcbb_tags.sv @@
// Key and size storage with a parallel key match and a lowest-free-slot search.
// Depends on lcbb_pkg.
module lcbb_tags (
  input  logic                 clk,
  input  logic                 wr_en,
  input  lcbb_pkg::slot_t      wr_slot,
  input  lcbb_pkg::key_t       key,
  input  lcbb_pkg::size_t      wr_size,
  input  logic [lcbb_pkg::ENTRIES-1:0] live,
  input  lcbb_pkg::slot_t      rd_slot,
  output lcbb_pkg::size_t      rd_size,
  output logic                 match_any,
  output lcbb_pkg::slot_t      match_slot,
  output logic                 free_any,
  output lcbb_pkg::slot_t      free_slot
);
  import lcbb_pkg::*;

  key_t  keys  [ENTRIES];
  size_t sizes [ENTRIES];

  // Entry write on insert.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_slot]  <= key;
      sizes[wr_slot] <= wr_size;
    end
  end

  assign rd_size = sizes[rd_slot];

  // Compare every live entry against the key; lowest index wins.
  always_comb begin
    match_any  = 1'b0;
    match_slot = '0;
    free_any   = 1'b0;
    free_slot  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (live[i] && keys[i] == key) begin
        match_any  = 1'b1;
        match_slot = SLOT_W'(i);
      end
      if (!live[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

endmodule

@@ rtl/lcbb_acc.sv @@
// Shared byte accumulator: one add/subtract unit and the compare against the budget.
// Depends on lcbb_pkg.
module lcbb_acc (
  input  logic                          clk,
  input  logic                          rst,
  input  lcbb_pkg::acc_cmd_t            cmd,
  input  lcbb_pkg::size_t               operand,
  input  logic [lcbb_pkg::BUDGET_W-1:0] budget,
  output lcbb_pkg::total_t              total,
  output logic                          over
);
  import lcbb_pkg::*;

  total_t total_next;
  total_t opnd;

  assign opnd = TOT_W'(operand);

  // One adder serves both growth on insert and shrink on eviction.
  always_comb begin
    total_next = total;
    if (cmd.clear) begin
      total_next = '0;
    end else if (cmd.add) begin
      total_next = total + opnd;
    end else if (cmd.sub) begin
      total_next = total - opnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  assign over = total > TOT_W'(budget);

endmodule

@@ rtl/lru_cache_byte_budget.sv @@
// Fully associative LRU tag store with a byte budget: top level and sequencer.
// Depends on lcbb_pkg, lcbb_tags and lcbb_acc.
//
// One item is taken at a time; input stall stays high from acceptance until the
// result transfer. A lookup, a touch, a clear, a miss or the unused mode passes
// from S_LOOK straight to S_OUT with its result. An insert of a new entry goes
// from S_LOOK through S_INS to S_EVICT, which it leaves for S_OUT once the total
// is within budget; evictions run one per cycle through the single shared byte
// adder. An item holds the block until its result is taken, so the next item waits.
// The budget register may be written at any idle time and is applied at the next
// insert. After reset the store is empty and ready at once.
module lru_cache_byte_budget (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_budget_we,
  input  logic [39:0] byte_budget,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] points_hash,
  input  logic [31:0] scale_code,
  input  logic [15:0] rotation_count,
  input  logic [15:0] rotation_index,
  input  logic [15:0] gutter,
  input  logic [39:0] entry_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        inserted,
  output logic [3:0]  slot,
  output logic        slot_valid,
  output logic [4:0]  evicted_now,
  output logic [39:0] bytes_in_use,
  output logic [31:0] eviction_total
);
  import lcbb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state;
  logic [BUDGET_W-1:0] budget;
  logic [1:0]          mode_r;
  key_t                key_r;
  size_t               bytes_r;
  logic [ENTRIES-1:0]  live;
  slot_t               rank [ENTRIES];
  logic [CNT_W-1:0]    count;
  logic [31:0]         evict_cnt;
  logic                hit_r;
  logic                ins_r;
  slot_t               slot_r;
  logic                slot_ok;
  logic [EVN_W-1:0]    evn;

  logic     match_any, free_any, over;
  slot_t    match_slot, free_slot, lru_slot;
  size_t    rd_size;
  acc_cmd_t cmd;
  total_t   total;
  slot_t    hit_rank;
  logic     tag_we;

  // Budget register.
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= BUDGET_RESET;
    end else if (byte_budget_we) begin
      budget <= byte_budget;
    end
  end

  // Capture the item on its transfer.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      mode_r  <= mode;
      key_r   <= '{points_hash, scale_code, rotation_count, rotation_index, gutter};
      bytes_r <= SIZE_WIDTH'(entry_bytes);
    end
  end

  // The least recent live entry carries rank count-1.
  always_comb begin
    lru_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i] && rank[i] == SLOT_W'(count - CNT_W'(1))) begin
        lru_slot = SLOT_W'(i);
      end
    end
  end

  assign hit_rank = rank[match_slot];
  assign tag_we   = (state == S_INS);

  lcbb_tags u_tags (
    .clk        (clk),
    .wr_en      (tag_we),
    .wr_slot    (slot_r),
    .key        (key_r),
    .wr_size    (bytes_r),
    .live       (live),
    .rd_slot    (lru_slot),
    .rd_size    (rd_size),
    .match_any  (match_any),
    .match_slot (match_slot),
    .free_any   (free_any),
    .free_slot  (free_slot)
  );

  // Accumulator command for the current step.
  always_comb begin
    cmd = '0;
    case (state)
      S_LOOK: begin
        if (mode_r == MODE_CLEAR) begin
          cmd.clear = 1'b1;
        end else if (mode_r == MODE_INSERT && !match_any && !free_any) begin
          cmd.sub = 1'b1;
        end
      end
      S_INS: begin
        cmd.add = 1'b1;
      end
      S_EVICT: begin
        cmd.sub = over;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  lcbb_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (tag_we ? bytes_r : rd_size),
    .budget  (budget),
    .total   (total),
    .over    (over)
  );

  // Sequencer, recency ranks and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      live      <= '0;
      count     <= '0;
      evict_cnt <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hit_r   <= 1'b0;
            ins_r   <= 1'b0;
            slot_r  <= '0;
            slot_ok <= 1'b0;
            evn     <= '0;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_OUT;
          if (mode_r == MODE_CLEAR) begin
            live  <= '0;
            count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
              rank[i] <= '0;
            end
          end else if ((mode_r == MODE_LOOKUP || mode_r == MODE_INSERT) && match_any) begin
            // Touch: entries more recent than the hit age by one.
            hit_r   <= 1'b1;
            slot_ok <= 1'b1;
            slot_r  <= match_slot;
            for (int i = 0; i < ENTRIES; i++) begin
              if (live[i] && rank[i] < hit_rank) begin
                rank[i] <= rank[i] + SLOT_W'(1);
              end
            end
            rank[match_slot] <= '0;
          end else if (mode_r == MODE_INSERT) begin
            state <= S_INS;
            if (free_any) begin
              slot_r <= free_slot;
            end else begin
              // Full table: the least recent entry gives up its slot.
              slot_r         <= lru_slot;
              live[lru_slot] <= 1'b0;
              count          <= count - CNT_W'(1);
              evn            <= EVN_W'(1);
              evict_cnt      <= evict_cnt + 32'd1;
            end
          end
        end
        S_INS: begin
          ins_r <= 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (live[i]) begin
              rank[i] <= rank[i] + SLOT_W'(1);
            end
          end
          rank[slot_r] <= '0;
          live[slot_r] <= 1'b1;
          count        <= count + CNT_W'(1);
          state        <= S_EVICT;
        end
        S_EVICT: begin
          if (over) begin
            live[lru_slot] <= 1'b0;
            count          <= count - CNT_W'(1);
            evn            <= evn + EVN_W'(1);
            evict_cnt      <= evict_cnt + 32'd1;
          end else begin
            slot_ok <= live[slot_r];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports.
  assign in_stall       = (state != S_IDLE);
  assign out_valid      = (state == S_OUT);
  assign hit            = hit_r;
  assign inserted       = ins_r;
  assign slot           = 4'(slot_r);
  assign slot_valid     = slot_ok;
  assign evicted_now    = 5'(evn);
  assign bytes_in_use   = BUDGET_W'(total);
  assign eviction_total = evict_cnt;

  // The live count tracks the valid bits.
  a_count : assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(live))
    else $error("live count out of step with valid bits");

  // An empty store holds no bytes while evicting.
  a_empty : assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT && count == '0) |-> total == '0)
    else $error("bytes held by an empty store");

  // A clear leaves no bytes behind.
  a_clear : assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && mode_r == MODE_CLEAR) |=> (total == '0 && live == '0))
    else $error("clear left state behind");

  // Leaving eviction means the total is within budget.
  a_budget : assert property (@(posedge clk) disable iff (rst)
    (state == S_EVICT && !over) |=> total <= TOT_W'(budget))
    else $error("total above budget after insert");

endmodule
